// ===== src/rcrc_pkg.sv =====
// Shared types, constants and the byte fold function of the reflected CRC-32 engine.
`default_nettype none
package rcrc_pkg;

  localparam int unsigned CrcWidth = 32;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CmdDepthDefault = 2;
  localparam int unsigned ResDepthDefault = 2;

  localparam logic [CrcWidth-1:0] CrcOnes = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] PolyReset = 32'h5AA5_A55A;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 byte_present;
    logic                 is_last;
  } cmd_t;

  function automatic logic [CrcWidth-1:0] fold_byte(
    input logic [CrcWidth-1:0]  crc,
    input logic [ByteWidth-1:0] data,
    input logic [CrcWidth-1:0]  poly
  );
    logic [CrcWidth-1:0] r;
    r = crc ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
    for (int k = 0; k < ByteWidth; k++) begin
      r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/rcrc_fifo.sv =====
// Small register-based first-in first-out queue.
`default_nettype none
module rcrc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/rcrc_front.sv =====
// Front end: accepts items and forwards only those that fold a byte or end a message.
`default_nettype none
module rcrc_front (
  input  wire logic                             push_i,
  output logic                                  full_o,
  input  wire logic [rcrc_pkg::ByteWidth-1:0]   data_byte_i,
  input  wire logic                             byte_present_i,
  input  wire logic                             is_last_i,
  output logic                                  cmd_push_o,
  output rcrc_pkg::cmd_t                        cmd_o,
  input  wire logic                             cmd_full_i
);

  logic useful;

  // An item with no byte that does not end a message changes nothing.
  assign useful     = byte_present_i || is_last_i;
  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i && !cmd_full_i && useful;

  always_comb begin
    cmd_o.data_byte    = data_byte_i;
    cmd_o.byte_present = byte_present_i;
    cmd_o.is_last      = is_last_i;
  end

endmodule
`default_nettype wire

// ===== src/rcrc_back.sv =====
// Back end: folds queued bytes into the CRC register and emits finished values.
`default_nettype none
module rcrc_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [rcrc_pkg::CrcWidth-1:0]   poly_i,
  input  wire rcrc_pkg::cmd_t                  cmd_i,
  input  wire logic                            cmd_empty_i,
  output logic                                 cmd_pop_o,
  output logic                                 res_push_o,
  output logic [rcrc_pkg::CrcWidth-1:0]        res_data_o,
  input  wire logic                            res_full_i
);

  logic [rcrc_pkg::CrcWidth-1:0] crc_q, crc_d, crc_next;

  assign cmd_pop_o  = !cmd_empty_i && (!cmd_i.is_last || !res_full_i);
  assign res_push_o = cmd_pop_o && cmd_i.is_last;

  always_comb begin
    crc_next = cmd_i.byte_present
             ? rcrc_pkg::fold_byte(crc_q, cmd_i.data_byte, poly_i) : crc_q;
    res_data_o = crc_next ^ rcrc_pkg::CrcOnes;
    crc_d = crc_q;
    if (cmd_pop_o) begin
      crc_d = cmd_i.is_last ? rcrc_pkg::CrcOnes : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= rcrc_pkg::CrcOnes;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/reflected_crc32_byte_engine_unit.sv =====
// Top level of the byte-serial reflected CRC-32 engine with a writable polynomial.
// Usage: message bytes enter through a queue-like port. An item is taken at a rising
// edge with push high and full low; it carries data_byte_i, byte_present_i and
// is_last_i. An item with is_last_i high finishes the message and yields one item on
// the result side, the register with any byte of that item folded in, XORed with
// all ones; the register then restarts at all ones. Results leave through empty and
// pop: crc_value_o is valid while empty is low and is taken at an edge with pop high.
// A result passes through the command queue and the result queue before it shows.
// Throughput: one item per cycle while the result queue is not full, set by the
// combinational eight-step fold in the back end. The polynomial is written through
// cfg_valid_i, cfg_ready_o and reflected_polynomial_i, always ready; write it only
// while the engine is idle. Reset clears both queues, sets the register to all ones
// and the polynomial to 0x5AA5A55A. When the receiver stalls, finished values wait
// in the result queue, then the command queue fills and full rises; nothing is lost.
`default_nettype none
module reflected_crc32_byte_engine_unit #(
  parameter int unsigned CmdDepth = rcrc_pkg::CmdDepthDefault,
  parameter int unsigned ResDepth = rcrc_pkg::ResDepthDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [rcrc_pkg::ByteWidth-1:0]  data_byte_i,
  input  wire logic                            byte_present_i,
  input  wire logic                            is_last_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [rcrc_pkg::CrcWidth-1:0]        crc_value_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [rcrc_pkg::CrcWidth-1:0]   reflected_polynomial_i
);

  logic [rcrc_pkg::CrcWidth-1:0] poly_q, poly_d;
  logic                          cmd_push, cmd_full, cmd_pop, cmd_empty;
  rcrc_pkg::cmd_t                cmd_in, cmd_out;
  logic                          res_push, res_full;
  logic [rcrc_pkg::CrcWidth-1:0] res_data;

  assign cfg_ready_o = 1'b1;
  assign poly_d = (cfg_valid_i && cfg_ready_o) ? reflected_polynomial_i : poly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= rcrc_pkg::PolyReset;
    end else begin
      poly_q <= poly_d;
    end
  end

  rcrc_front u_front (
    .push_i         (push),
    .full_o         (full),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .is_last_i      (is_last_i),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in),
    .cmd_full_i     (cmd_full)
  );

  rcrc_fifo #(
    .Width ($bits(rcrc_pkg::cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  rcrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .poly_i      (poly_q),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_data_o  (res_data),
    .res_full_i  (res_full)
  );

  rcrc_fifo #(
    .Width (rcrc_pkg::CrcWidth),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (crc_value_o),
    .empty_o (empty)
  );

endmodule
`default_nettype wire
